>>> hw/rtl/mpbc_pkg.sv
package mpbc_pkg;

  localparam int PIX_W       = 8;
  localparam int TIDX_W      = 8;
  localparam int COST_W      = 32;
  localparam int SUM_W       = 44;
  localparam int POS_W       = 12;
  localparam int CFG_W       = 13;
  localparam int BS_CFG_W    = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int TABLE_DEPTH = 256;

  localparam int FRAME_WIDTH_RESET  = 64;
  localparam int FRAME_HEIGHT_RESET = 64;
  localparam int BLOCK_SIZE_RESET   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;

  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [PIX_W-1:0] PRED_FIRST = 8'd128;
  localparam logic [PIX_W:0]   PIX_MAX    = 9'd255;

  typedef struct packed {
    logic             x0;
    logic             y0;
    logic             first;
    logic             blk_done;
    logic             frame_done;
    logic [POS_W-1:0] block_row;
    logic [POS_W-1:0] block_col;
  } pos_info_t;

  typedef struct packed {
    logic [POS_W-1:0]        block_row;
    logic [POS_W-1:0]        block_col;
    logic signed [SUM_W-1:0] block_cost;
    logic                    frame_done;
  } result_t;

  function automatic logic [PIX_W-1:0] med_predict(input logic [PIX_W-1:0] n,
                                                  input logic [PIX_W-1:0] w,
                                                  input logic [PIX_W-1:0] nw);
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [PIX_W:0]   planar;
    hi = (n > w) ? n : w;
    lo = (n < w) ? n : w;
    planar = {1'b0, n} + {1'b0, w} - {1'b0, nw};
    if (nw >= hi) begin
      return lo;
    end else if (nw <= lo) begin
      return hi;
    end else if (planar > PIX_MAX) begin
      return PIX_MAX[PIX_W-1:0];
    end else begin
      return planar[PIX_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/mpbc_in_if.sv
interface mpbc_in_if;
  import mpbc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [PIX_W-1:0]         pixel;
  logic [TIDX_W-1:0]        table_index;
  logic signed [COST_W-1:0] table_value;

  modport source(output valid, output mode, output pixel, output table_index,
                 output table_value, input ready);
  modport sink(input valid, input mode, input pixel, input table_index,
               input table_value, output ready);
endinterface

>>> hw/rtl/mpbc_out_if.sv
interface mpbc_out_if;
  import mpbc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        block_row;
  logic [POS_W-1:0]        block_col;
  logic signed [SUM_W-1:0] block_cost;
  logic                    frame_done;

  modport source(output valid, output block_row, output block_col, output block_cost,
                 output frame_done, input ready);
  modport sink(input valid, input block_row, input block_col, input block_cost,
               input frame_done, output ready);
endinterface

>>> hw/rtl/med_prediction_block_cost.sv
// A pixel item passes through the s1 and s2 registers into the output register; only the pixel that
// ends a block gives a result, and table-load items give none. Throughput: one item per cycle while
// the output buffer has space, set by the single read-modify-write of the block sum memory.
// The sum of one pixel is forwarded to the next pixel of the same block.
// Reset is synchronous and active high; it sets the registers to their defaults and
// restarts the frame. A write to the frame width, frame height or block size register restarts it as well.
module med_prediction_block_cost #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_BLOCK  = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  mpbc_in_if.sink                        in_ch,
  mpbc_out_if.source                     out_ch,
  input  logic                           cfg_write,
  input  logic [mpbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpbc_pkg::CFG_W-1:0]     cfg_data
);
  import mpbc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int TW = $clog2(TABLE_DEPTH);

  logic      en;
  logic      accept;
  logic      restart;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] pos_bc;
  pos_info_t pos_info;

  logic                     s1_valid;
  logic                     s1_mode;
  logic [PIX_W-1:0]         s1_pixel;
  logic [TIDX_W-1:0]        s1_tidx;
  logic [COST_W-1:0]        s1_tval;
  logic [XW-1:0]            s1_bc;
  pos_info_t                s1_info;
  logic [PIX_W-1:0]         north;
  logic [PIX_W-1:0]         west;
  logic [PIX_W-1:0]         northwest;
  logic [PIX_W-1:0]         pred;
  logic [TW-1:0]            residual;

  logic                     s2_valid;
  logic [XW-1:0]            s2_bc;
  pos_info_t                s2_info;
  logic                     fwd;
  logic signed [SUM_W-1:0]  fwd_val;
  logic [COST_W-1:0]        cost_raw;
  logic [SUM_W-1:0]         sum_raw;
  logic signed [SUM_W-1:0]  cost;
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  sum;

  logic    push;
  result_t push_data;

  assign accept       = in_ch.valid && en;
  assign in_ch.ready  = en;

  mpbc_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_position (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (accept && in_ch.mode == MODE_PIXEL),
    .restart  (restart),
    .x        (pos_x),
    .bc       (pos_bc),
    .info     (pos_info)
  );

  mpbc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_prev_row (
    .clk  (clk),
    .re   (en),
    .raddr(pos_x),
    .rdata(north),
    .we   (accept && in_ch.mode == MODE_PIXEL),
    .waddr(pos_x),
    .wdata(in_ch.pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode  <= in_ch.mode;
      s1_pixel <= in_ch.pixel;
      s1_tidx  <= in_ch.table_index;
      s1_tval  <= in_ch.table_value;
      s1_bc    <= pos_bc;
      s1_info  <= pos_info;
    end
  end

  always_comb begin
    if (s1_info.y0) begin
      pred = s1_info.x0 ? PRED_FIRST : west;
    end else if (s1_info.x0) begin
      pred = north;
    end else begin
      pred = med_predict(north, west, northwest);
    end
    residual = TW'(s1_pixel - pred);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      west      <= '0;
      northwest <= '0;
    end else if (en && s1_valid && s1_mode == MODE_PIXEL) begin
      west      <= s1_pixel;
      northwest <= north;
    end
  end

  mpbc_ram #(
    .WIDTH(COST_W),
    .DEPTH(TABLE_DEPTH)
  ) u_cost_table (
    .clk  (clk),
    .re   (en),
    .raddr(residual),
    .rdata(cost_raw),
    .we   (en && s1_valid && s1_mode == MODE_TABLE),
    .waddr(TW'(s1_tidx)),
    .wdata(s1_tval)
  );

  mpbc_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_block_sums (
    .clk  (clk),
    .re   (en),
    .raddr(s1_bc),
    .rdata(sum_raw),
    .we   (en && s2_valid),
    .waddr(s2_bc),
    .wdata(sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_mode == MODE_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bc   <= s1_bc;
      s2_info <= s1_info;
      fwd     <= s2_valid && (s2_bc == s1_bc);
      fwd_val <= sum;
    end
  end

  always_comb begin
    cost = {{(SUM_W - COST_W){cost_raw[COST_W-1]}}, cost_raw};
    if (s2_info.first) begin
      base = '0;
    end else if (fwd) begin
      base = fwd_val;
    end else begin
      base = sum_raw;
    end
    sum = base + cost;
  end

  assign push = en && s2_valid && s2_info.blk_done;

  always_comb begin
    push_data.block_row  = s2_info.block_row;
    push_data.block_col  = s2_info.block_col;
    push_data.block_cost = sum;
    push_data.frame_done = s2_info.frame_done;
  end

  mpbc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .space    (en),
    .out_ch   (out_ch)
  );

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_mode == MODE_PIXEL && s1_info.frame_done) |-> s1_info.blk_done)
    else $error("frame end reached without a finished block");

  assert property (@(posedge clk) disable iff (rst)
    restart |=> (pos_x == '0))
    else $error("register write did not restart the frame");

  assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled while no result is waiting");

endmodule

>>> hw/rtl/mpbc_ram.sv
module mpbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/mpbc_position.sv
module mpbc_position #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_BLOCK  = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mpbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpbc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             step,
  output logic                             restart,
  output logic [$clog2(MAX_WIDTH)-1:0]     x,
  output logic [$clog2(MAX_WIDTH)-1:0]     bc,
  output mpbc_pkg::pos_info_t              info
);
  import mpbc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int BW = $clog2(MAX_BLOCK);

  localparam logic [XW-1:0] RST_W_LAST =
    XW'((MAX_WIDTH < FRAME_WIDTH_RESET ? MAX_WIDTH : FRAME_WIDTH_RESET) - 1);
  localparam logic [YW-1:0] RST_H_LAST =
    YW'((MAX_HEIGHT < FRAME_HEIGHT_RESET ? MAX_HEIGHT : FRAME_HEIGHT_RESET) - 1);
  localparam logic [BW-1:0] RST_BS_LAST =
    BW'((MAX_BLOCK < BLOCK_SIZE_RESET ? MAX_BLOCK : BLOCK_SIZE_RESET) - 1);

  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;
  logic [BW-1:0] bs_last;
  logic [XW-1:0] col, col_next;
  logic [YW-1:0] row, row_next;
  logic [BW-1:0] cib, cib_next;
  logic [BW-1:0] rib, rib_next;
  logic [XW-1:0] bcol, bcol_next;
  logic [YW-1:0] brow, brow_next;
  logic          row_end;
  logic          col_end;
  logic [BS_CFG_W-1:0] bs_data;

  assign bs_data = cfg_data[BS_CFG_W-1:0];
  assign restart = cfg_write && (cfg_index == CFG_FRAME_WIDTH ||
                                 cfg_index == CFG_FRAME_HEIGHT ||
                                 cfg_index == CFG_BLOCK_SIZE);

  assign row_end = (col == w_last);
  assign col_end = (row == h_last);

  always_comb begin
    info.x0         = (col == '0);
    info.y0         = (row == '0);
    info.first      = (cib == '0) && (rib == '0);
    info.blk_done   = (cib == bs_last || row_end) && (rib == bs_last || col_end);
    info.frame_done = row_end && col_end;
    info.block_row  = POS_W'(brow);
    info.block_col  = POS_W'(bcol);
  end

  assign x  = col;
  assign bc = bcol;

  always_comb begin
    col_next  = col;
    row_next  = row;
    cib_next  = cib;
    rib_next  = rib;
    bcol_next = bcol;
    brow_next = brow;
    if (row_end) begin
      col_next  = '0;
      cib_next  = '0;
      bcol_next = '0;
      if (col_end) begin
        row_next  = '0;
        rib_next  = '0;
        brow_next = '0;
      end else begin
        row_next = row + 1'b1;
        if (rib >= bs_last) begin
          rib_next  = '0;
          brow_next = brow + 1'b1;
        end else begin
          rib_next = rib + 1'b1;
        end
      end
    end else begin
      col_next = col + 1'b1;
      if (cib >= bs_last) begin
        cib_next  = '0;
        bcol_next = bcol + 1'b1;
      end else begin
        cib_next = cib + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= RST_W_LAST;
      h_last  <= RST_H_LAST;
      bs_last <= RST_BS_LAST;
      col     <= '0;
      row     <= '0;
      cib     <= '0;
      rib     <= '0;
      bcol    <= '0;
      brow    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            w_last <= '0;
          end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
            w_last <= XW'(MAX_WIDTH - 1);
          end else begin
            w_last <= XW'(cfg_data - 1'b1);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            h_last <= '0;
          end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
            h_last <= YW'(MAX_HEIGHT - 1);
          end else begin
            h_last <= YW'(cfg_data - 1'b1);
          end
        end
        CFG_BLOCK_SIZE: begin
          if (bs_data == '0) begin
            bs_last <= '0;
          end else if (32'(bs_data) > 32'(MAX_BLOCK)) begin
            bs_last <= BW'(MAX_BLOCK - 1);
          end else begin
            bs_last <= BW'(bs_data - 1'b1);
          end
        end
        default: begin
        end
      endcase
      if (restart) begin
        col  <= '0;
        row  <= '0;
        cib  <= '0;
        rib  <= '0;
        bcol <= '0;
        brow <= '0;
      end
    end else if (step) begin
      col  <= col_next;
      row  <= row_next;
      cib  <= cib_next;
      rib  <= rib_next;
      bcol <= bcol_next;
      brow <= brow_next;
    end
  end

endmodule

>>> hw/rtl/mpbc_out_buf.sv
module mpbc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mpbc_pkg::result_t push_data,
  output logic              space,
  mpbc_out_if.source        out_ch
);
  import mpbc_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign space = !skid_valid;

  assign out_ch.valid      = out_valid;
  assign out_ch.block_row  = out_data.block_row;
  assign out_ch.block_col  = out_data.block_col;
  assign out_ch.block_cost = out_data.block_cost;
  assign out_ch.frame_done = out_data.frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ch.ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule
